### rtl/aes_pkg.sv
package aes_pkg;

  localparam int unsigned BlockBytes  = 16;
  localparam int unsigned RkDepth     = 60;
  localparam int unsigned CfgIdxW     = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_KEY0    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY1    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY2    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY3    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MODE    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_CTRW    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CTR_HI  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_CTR_LO  = 3'd7;

  localparam logic [7:0] GfPoly = 8'h1b;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? GfPoly : 8'h00);
  endfunction

  // control from sequencer to round unit
  typedef struct packed {
    logic load;     // load counter block and add round key 0
    logic step;     // apply one round
    logic last;     // final round, no mix columns
  } rnd_ctl_t;

endpackage

### rtl/aes_round.sv
// One AES round per cycle while ctl.step is high, on a 128-bit state; state byte i in bits [127-8i -: 8].
module aes_round (
  input  logic             clk,
  input  aes_pkg::rnd_ctl_t ctl,
  input  logic [127:0]     blk_in,
  input  logic [127:0]     rkey,
  output logic [127:0]     state
);

  logic [127:0] state_r;
  logic [127:0] ss;
  logic [127:0] mc;
  logic [127:0] state_nxt;

  // sub bytes and shift rows
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        ss[127 - 8*(r + 4*c) -: 8] =
          aes_pkg::sbox(state_r[127 - 8*(r + 4*((c + r) % 4)) -: 8]);
      end
    end
  end

  // mix columns
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3;
      a0 = ss[127 - 8*(4*c)     -: 8];
      a1 = ss[127 - 8*(4*c + 1) -: 8];
      a2 = ss[127 - 8*(4*c + 2) -: 8];
      a3 = ss[127 - 8*(4*c + 3) -: 8];
      mc[127 - 8*(4*c)     -: 8] = aes_pkg::xtime(a0) ^ aes_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
      mc[127 - 8*(4*c + 1) -: 8] = a0 ^ aes_pkg::xtime(a1) ^ aes_pkg::xtime(a2) ^ a2 ^ a3;
      mc[127 - 8*(4*c + 2) -: 8] = a0 ^ a1 ^ aes_pkg::xtime(a2) ^ aes_pkg::xtime(a3) ^ a3;
      mc[127 - 8*(4*c + 3) -: 8] = aes_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ aes_pkg::xtime(a3);
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (ctl.load) begin
      state_nxt = blk_in ^ rkey;
    end else if (ctl.step) begin
      state_nxt = (ctl.last ? ss : mc) ^ rkey;
    end
  end

  always_ff @(posedge clk) begin
    state_r <= state_nxt;
  end

  assign state = state_r;

endmodule

### rtl/aes_ctr_keystream_xor_top.sv
// Channel | Dir | Handshake           | Payload
// in      | in  | in_tvalid/in_tready | tdata = data_in, tuser = {end_of_message, restart}
// out     | out | out_tvalid/tready   | tdata = data_out
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
// Byte within a block: accepted in S_IDLE, then the result is registered in S_OUT.
// Byte at block start: the counter block is encrypted first; for each of the Nr+1 round keys
//   four round key words are read from memory, then the round itself is applied.
// Restart: key expansion adds one round-key word per cycle, 4*(Nr+1) words in all.
// rst_n is synchronous; round key memory holds no reset.
// in_tready is low while a result waits or an item is being worked on.
module aes_ctr_keystream_xor_top #(
  parameter int unsigned BLOCK_BYTES = aes_pkg::BlockBytes
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_in
  input  logic [1:0]  in_tuser,   // [0] restart, [1] end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] data_out
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [aes_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int unsigned PosW = $clog2(BLOCK_BYTES);

  typedef enum logic [2:0] {
    S_IDLE, S_KEXP, S_ENC_LD, S_ENC, S_OUT
  } state_t;

  // configuration
  logic [63:0] key_r [4];
  logic [1:0]  mode_r;
  logic [4:0]  ctrw_r;
  logic [63:0] ctr_hi_r, ctr_lo_r;

  state_t       st_r;
  logic [127:0] ctr_r;
  logic [127:0] ks_r;
  logic [PosW-1:0] pos_r;
  logic         kready_r;
  logic [3:0]   nr_r;
  logic [2:0]   nk_r;
  logic [5:0]   widx_r;      // expansion word index
  logic [2:0]   wmod_r;      // widx % nk
  logic [7:0]   rcon_r;
  logic [3:0]   rnd_r;
  logic [1:0]   col_r;       // round key word fetch within round
  logic [7:0]   data_r;
  logic         eom_r;
  logic [7:0]   out_r;
  logic         ovld_r;

  // round key memory and small window of last 8 words for expansion
  logic [31:0] rk_mem [aes_pkg::RkDepth];
  logic [31:0] win_r [8];
  logic [31:0] rk_rd_r;
  logic [127:0] rkey_r;
  logic [5:0]  rd_addr;

  assign cfg_ready = 1'b1;
  assign in_tready = (st_r == S_IDLE) && !ovld_r;
  assign out_tvalid = ovld_r;
  assign out_tdata  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0] <= '0; key_r[1] <= '0; key_r[2] <= '0; key_r[3] <= '0;
      mode_r <= '0; ctrw_r <= 5'd16; ctr_hi_r <= '0; ctr_lo_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        aes_pkg::REG_KEY0:   key_r[0] <= cfg_data;
        aes_pkg::REG_KEY1:   key_r[1] <= cfg_data;
        aes_pkg::REG_KEY2:   key_r[2] <= cfg_data;
        aes_pkg::REG_KEY3:   key_r[3] <= cfg_data;
        aes_pkg::REG_MODE:   mode_r <= cfg_data[1:0];
        aes_pkg::REG_CTRW:   ctrw_r <= cfg_data[4:0];
        aes_pkg::REG_CTR_HI: ctr_hi_r <= cfg_data;
        aes_pkg::REG_CTR_LO: ctr_lo_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // next expansion word
  logic [31:0] kw_prev, kw_t, kw_new, kw_cfg;
  always_comb begin
    kw_cfg  = widx_r[0] ? key_r[widx_r[2:1]][31:0] : key_r[widx_r[2:1]][63:32];
    kw_prev = win_r[0];
    kw_t    = kw_prev;
    if (wmod_r == 3'd0) begin
      kw_t = aes_pkg::sub_word({kw_prev[23:0], kw_prev[31:24]}) ^ {rcon_r, 24'h0};
    end else if (nk_r == 3'd0 && wmod_r == 3'd4) begin
      kw_t = aes_pkg::sub_word(kw_prev);
    end
    // nk_r encodes Nk as 4/6/0(=8); window holds previous 8 words, newest at 0
    case (nk_r)
      3'd4:    kw_new = win_r[3] ^ kw_t;
      3'd6:    kw_new = win_r[5] ^ kw_t;
      default: kw_new = win_r[7] ^ kw_t;
    endcase
  end

  logic [5:0] nkw;
  assign nkw = (nk_r == 3'd0) ? 6'd8 : {3'd0, nk_r};
  logic [5:0] total_w;
  assign total_w = {nr_r, 2'b00} + 6'd4;

  // counter increment, bytes 15 down to 16-n
  logic [127:0] ctr_inc;
  always_comb begin
    logic carry;
    logic [4:0] n;
    n = (ctrw_r > 5'd16) ? 5'd16 : ctrw_r;
    carry = 1'b1;
    ctr_inc = ctr_r;
    for (int k = 0; k < 16; k++) begin
      if (k < n && carry) begin
        ctr_inc[8*k +: 8] = ctr_r[8*k +: 8] + 8'd1;
        carry = (ctr_r[8*k +: 8] == 8'hff);
      end
    end
  end

  aes_pkg::rnd_ctl_t rctl;
  logic [127:0] rstate;
  assign rctl.load = (st_r == S_ENC_LD) && (col_r == 2'd3);
  assign rctl.step = (st_r == S_ENC) && (col_r == 2'd3);
  assign rctl.last = (rnd_r == nr_r);

  aes_round u_round (
    .clk    (clk),
    .ctl    (rctl),
    .blk_in (ctr_r),
    .rkey   ({rkey_r[95:0], rk_rd_r}),
    .state  (rstate)
  );

  // round key read pipeline: address runs one word ahead, data next cycle
  logic fetch_r;
  assign rd_addr = {rnd_r, col_r + {1'b0, fetch_r}};
  always_ff @(posedge clk) begin
    rk_rd_r <= rk_mem[rd_addr];
    if (st_r == S_KEXP) rk_mem[widx_r] <= (widx_r < nkw) ? kw_cfg : kw_new;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; kready_r <= 1'b0; ovld_r <= 1'b0; pos_r <= '0;
      ks_r <= '0; ctr_r <= '0; nr_r <= 4'd10; nk_r <= 3'd4;
      rnd_r <= '0; col_r <= '0; fetch_r <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) ovld_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            data_r <= in_tdata;
            eom_r  <= in_tuser[1];
            if (in_tuser[0] || !kready_r) begin
              kready_r <= 1'b1;
              ctr_r <= {ctr_hi_r, ctr_lo_r};
              pos_r <= '0;
              nr_r  <= (mode_r == 2'd0) ? 4'd10 : (mode_r == 2'd1) ? 4'd12 : 4'd14;
              nk_r  <= (mode_r == 2'd0) ? 3'd4 : (mode_r == 2'd1) ? 3'd6 : 3'd0;
              widx_r <= '0; wmod_r <= '0; rcon_r <= 8'h01;
              st_r <= S_KEXP;
            end else if (pos_r == '0) begin
              rnd_r <= '0; col_r <= '0; st_r <= S_ENC_LD;
            end else begin
              st_r <= S_OUT;
            end
          end
        end
        S_KEXP: begin
          for (int j = 7; j > 0; j--) win_r[j] <= win_r[j-1];
          win_r[0] <= (widx_r < nkw) ? kw_cfg : kw_new;
          if (widx_r >= nkw && wmod_r == 3'd0)
            rcon_r <= aes_pkg::xtime(rcon_r);
          wmod_r <= ({3'd0, wmod_r} + 6'd1 == nkw) ? 3'd0 : wmod_r + 3'd1;
          widx_r <= widx_r + 6'd1;
          if (widx_r + 6'd1 == total_w) begin
            rnd_r <= '0; col_r <= '0; st_r <= S_ENC_LD;
          end
        end
        S_ENC_LD, S_ENC: begin
          // collect four key words, then apply the round
          rkey_r <= {rkey_r[95:0], rk_rd_r};
          fetch_r <= 1'b1;
          if (col_r != 2'd3 || !fetch_r) begin
            if (fetch_r || col_r != 2'd0) col_r <= col_r + 2'd1;
            else col_r <= col_r;
          end else begin
            fetch_r <= 1'b0;
            col_r <= '0;
            if (st_r == S_ENC && rnd_r == nr_r) begin
              st_r <= S_OUT;
            end else begin
              rnd_r <= rnd_r + 4'd1;
              st_r <= S_ENC;
            end
          end
        end
        S_OUT: begin
          if (pos_r == '0 && fetch_r == 1'b0 && rnd_r == nr_r) begin
            ks_r  <= rstate;
            ctr_r <= ctr_inc;
            out_r <= data_r ^ rstate[127 -: 8];
            rnd_r <= '0;
          end else begin
            out_r <= data_r ^ ks_r[127 - 8*pos_r -: 8];
          end
          ovld_r <= 1'b1;
          pos_r  <= eom_r ? '0 : pos_r + 1'b1;
          st_r   <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // result register never overwritten while still waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (ovld_r && !out_tready) |=> ovld_r && $stable(out_r))
    else $error("result lost");
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !in_tready)
    else $error("ready while busy");
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT) |=> ovld_r && st_r == S_IDLE)
    else $error("result not raised");

endmodule
